// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// The expression must hold at every clock edge.
`define PLU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== rtl/plu_pkg.sv =====
// ----------------------------------------------------------------------------
// plu_pkg
// Types, constants and helpers shared by the particle leapfrog update block.
// ----------------------------------------------------------------------------
package plu_pkg;

  // Fixed-point format of every vector component.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Iterative units: two iterations per pipeline stage.
  localparam int SQ_ITERS      = 32;
  localparam int SQ_PER_STAGE  = 2;
  localparam int SQ_STAGES     = SQ_ITERS / SQ_PER_STAGE;
  localparam int DIV_BITS      = 32;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

  // Pipeline stage map.
  localparam int S_IN    = 0;                      // input capture, gravity add
  localparam int S_SQ    = 1;                      // squares and limit products
  localparam int S_SUM   = 2;                      // magnitude squared, compare
  localparam int S_ROOT0 = 3;                      // first square root stage
  localparam int S_DIV0  = S_ROOT0 + SQ_STAGES;    // first divider stage
  localparam int S_V1    = S_DIV0 + DIV_STAGES;    // force select, dt*f, k*xsph
  localparam int S_V2    = S_V1 + 1;               // new velocity
  localparam int S_V3    = S_V2 + 1;               // position step, mean
  localparam int S_V4    = S_V3 + 1;               // scaled position step
  localparam int NUM_STAGES = S_V4 + 1;

  // Configuration port.
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_TIME_STEP     = 3'd0,
    REG_GRAVITY_Z     = 3'd1,
    REG_SPEED_LIMIT   = 3'd2,
    REG_XSPH_FACTOR   = 3'd3,
    REG_INV_SIM_SCALE = 3'd4
  } reg_idx_t;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic        [16:0] time_step;
    logic signed [24:0] gravity_z;
    logic        [30:0] speed_limit;
    logic        [16:0] xsph_factor;
    logic        [30:0] inv_sim_scale;
  } cfg_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t vel_x;
    word_t vel_y;
    word_t vel_z;
    word_t force_x;
    word_t force_y;
    word_t force_z;
    word_t xsph_x;
    word_t xsph_y;
    word_t xsph_z;
  } in_item_t;

  typedef struct packed {
    word_t new_pos_x;
    word_t new_pos_y;
    word_t new_pos_z;
    word_t new_vel_x;
    word_t new_vel_y;
    word_t new_vel_z;
    word_t mean_vel_x;
    word_t mean_vel_y;
    word_t mean_vel_z;
  } out_item_t;

  // Clamp a wide signed value to the signed word range.
  function automatic word_t sat_word(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[WORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/plu_if.sv =====
// ----------------------------------------------------------------------------
// plu_if
// Valid/ready channels for input requests and result requests.
// ----------------------------------------------------------------------------
interface plu_in_if;
  import plu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plu_out_if;
  import plu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/plu_cfg.sv =====
// ----------------------------------------------------------------------------
// plu_cfg
// APB register file holding the five step parameters.
// ----------------------------------------------------------------------------
module plu_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [plu_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [plu_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [plu_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output plu_pkg::cfg_t                      cfg
);
  import plu_pkg::*;

  logic        [16:0] ts_r;
  logic signed [24:0] gz_r;
  logic        [30:0] sl_r;
  logic        [16:0] xf_r;
  logic        [30:0] iss_r;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= 17'd66;
      gz_r  <= -25'sd642253;
      sl_r  <= 31'd39321600;
      xf_r  <= 17'd6554;
      iss_r <= 31'd65536;
    end else if (wr_en) begin
      case (idx)
        REG_TIME_STEP:     ts_r  <= pwdata[16:0];
        REG_GRAVITY_Z:     gz_r  <= signed'(pwdata[24:0]);
        REG_SPEED_LIMIT:   sl_r  <= pwdata[30:0];
        REG_XSPH_FACTOR:   xf_r  <= pwdata[16:0];
        REG_INV_SIM_SCALE: iss_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read back the stored values.
  always_comb begin
    case (idx)
      REG_TIME_STEP:     prdata = {15'd0, ts_r};
      REG_GRAVITY_Z:     prdata = unsigned'(32'(gz_r));
      REG_SPEED_LIMIT:   prdata = {1'b0, sl_r};
      REG_XSPH_FACTOR:   prdata = {15'd0, xf_r};
      REG_INV_SIM_SCALE: prdata = {1'b0, iss_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.time_step     = ts_r;
  assign cfg.gravity_z     = gz_r;
  assign cfg.speed_limit   = sl_r;
  assign cfg.xsph_factor   = xf_r;
  assign cfg.inv_sim_scale = iss_r;

endmodule

// ===== rtl/plu_isqrt.sv =====
// ----------------------------------------------------------------------------
// plu_isqrt
// Pipelined 64-bit integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module plu_isqrt (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import plu_pkg::*;

  logic [63:0] rem_r   [SQ_STAGES];
  logic [63:0] res_r   [SQ_STAGES];
  logic [63:0] rem_nxt [SQ_STAGES];
  logic [63:0] res_nxt [SQ_STAGES];

  // Digit-by-digit root: each stage retires two iterations.
  always_comb begin
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        n = rad;
        r = '0;
      end else begin
        n = rem_r[k-1];
        r = res_r[k-1];
      end
      for (int j = 0; j < SQ_PER_STAGE; j++) begin
        b = 64'd1 << (62 - 2 * (k * SQ_PER_STAGE + j));
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      rem_nxt[k] = n;
      res_nxt[k] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign root = res_r[SQ_STAGES-1][31:0];

endmodule

// ===== rtl/plu_div.sv =====
// ----------------------------------------------------------------------------
// plu_div
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, two
// quotient bits per stage. The quotient must fit in DIV_BITS bits.
// ----------------------------------------------------------------------------
module plu_div (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import plu_pkg::*;

  logic [63:0]         rem_r   [DIV_STAGES];
  logic [31:0]         den_r   [DIV_STAGES];
  logic [DIV_BITS-1:0] quo_r   [DIV_STAGES];
  logic [63:0]         rem_nxt [DIV_STAGES];
  logic [DIV_BITS-1:0] quo_nxt [DIV_STAGES];

  // Compare and subtract the shifted divisor, most significant bit first.
  always_comb begin
    logic [63:0]         rm;
    logic [63:0]         dv;
    logic [31:0]         d;
    logic [DIV_BITS-1:0] q;
    int                  bi;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rm = num;
        d  = den;
        q  = '0;
      end else begin
        rm = rem_r[k-1];
        d  = den_r[k-1];
        q  = quo_r[k-1];
      end
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        bi = DIV_BITS - 1 - (k * DIV_PER_STAGE + j);
        dv = 64'(d) << bi;
        if (rm >= dv) begin
          rm    = rm - dv;
          q[bi] = 1'b1;
        end
      end
      rem_nxt[k] = rm;
      quo_nxt[k] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        if (k == 0) begin
          den_r[k] <= den;
        end else begin
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = 32'(quo_r[DIV_STAGES-1]);

endmodule

// ===== rtl/particle_leapfrog_update.sv =====
// ----------------------------------------------------------------------------
// particle_leapfrog_update
// Leapfrog time step of one particle in Q16.16 with force limiting and XSPH.
// ----------------------------------------------------------------------------
// The block takes one particle request per cycle while the output buffer
// has room and returns one result per request, in order. The 39-stage
// pipeline has three front stages, a 16-stage integer square root and a
// 16-stage divider (two bits per stage each) for the force limit, and four
// integration stages, followed by a two-entry output buffer. The pipeline
// advances whenever the buffer has room, so requests keep flowing while one
// result waits to be taken.
// Write the registers over APB only while no request is in flight.
module particle_leapfrog_update (
  input  logic                              clk,
  input  logic                              rst_n,
  plu_in_if.sink                            in_ch,
  plu_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plu_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [plu_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [plu_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import plu_pkg::*;

  cfg_t cfg;

  // Pipeline control.
  logic                  adv;
  logic                  push;
  logic                  pop;
  logic [NUM_STAGES-1:0] vld_r;

  // Carried vectors.
  word_t pos_r [0:S_V4][3];
  word_t vel_r [0:S_V3-1][3];
  word_t xs_r  [0:S_V1-1][3];
  word_t frc_r [0:S_V1-1][3];
  word_t pos_in [3];
  word_t vel_in [3];
  word_t xs_in  [3];
  word_t frc_in [3];

  // Force limit path.
  logic [63:0] sq_r    [3];
  logic [63:0] sq_nxt  [3];
  logic [61:0] lim2_r;
  logic [61:0] lim2_nxt;
  logic [61:0] num_r   [S_SQ:S_DIV0-1][3];
  logic [61:0] num_nxt [3];
  logic [63:0] sum_r;
  logic [63:0] sum_nxt;
  logic        over_r  [S_SUM:S_V1-1];
  logic        over_nxt;
  logic [31:0] root;
  logic [31:0] quo [3];

  // Integration path.
  logic signed [33:0] t1_r    [3];
  logic signed [33:0] t1_nxt  [3];
  logic signed [33:0] t2_r    [3];
  logic signed [33:0] t2_nxt  [3];
  word_t              vn_r    [S_V2:S_V4][3];
  word_t              vn_nxt  [3];
  word_t              step_r  [3];
  word_t              step_nxt[3];
  word_t              mean_r  [S_V3:S_V4][3];
  word_t              mean_nxt[3];
  logic signed [47:0] ps_r    [3];
  logic signed [47:0] ps_nxt  [3];
  word_t              np      [3];
  out_item_t          item_nxt;

  // Output buffer.
  out_item_t   obuf_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;

  plu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The whole pipeline moves while the output buffer has a free entry.
  assign adv         = (cnt_r != 2'd2);
  assign in_ch.ready = adv;
  assign push        = adv & vld_r[NUM_STAGES-1];
  assign pop         = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_ch.valid};
    end
  end

  // Unpack the request and add gravity to force z.
  always_comb begin
    pos_in[0] = in_ch.data.pos_x;
    pos_in[1] = in_ch.data.pos_y;
    pos_in[2] = in_ch.data.pos_z;
    vel_in[0] = in_ch.data.vel_x;
    vel_in[1] = in_ch.data.vel_y;
    vel_in[2] = in_ch.data.vel_z;
    xs_in[0]  = in_ch.data.xsph_x;
    xs_in[1]  = in_ch.data.xsph_y;
    xs_in[2]  = in_ch.data.xsph_z;
    frc_in[0] = in_ch.data.force_x;
    frc_in[1] = in_ch.data.force_y;
    frc_in[2] = sat_word(64'(in_ch.data.force_z) + 64'(cfg.gravity_z));
  end

  // Squares of the force, the squared limit and |f| times the limit.
  always_comb begin
    logic signed [63:0] sqs;
    logic        [31:0] mag;
    for (int i = 0; i < 3; i++) begin
      sqs       = 64'(frc_r[S_IN][i]) * 64'(frc_r[S_IN][i]);
      sq_nxt[i] = unsigned'(sqs);
      mag       = frc_r[S_IN][i][WORD_BITS-1] ? unsigned'(-frc_r[S_IN][i])
                                              : unsigned'(frc_r[S_IN][i]);
      num_nxt[i] = 62'(64'(mag) * 64'(cfg.speed_limit));
    end
    lim2_nxt = 62'(62'(cfg.speed_limit) * 62'(cfg.speed_limit));
  end

  // Magnitude squared and the limit test.
  assign sum_nxt  = sq_r[0] + sq_r[1] + sq_r[2];
  assign over_nxt = sum_nxt > 64'(lim2_r);

  plu_isqrt u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (sum_r),
    .root (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    plu_div u_div (
      .clk (clk),
      .adv (adv),
      .num (64'(num_r[S_DIV0-1][g])),
      .den (root),
      .quo (quo[g])
    );
  end

  // Select the limited force, then weight by dt and by the XSPH factor.
  always_comb begin
    word_t              qs;
    word_t              fl;
    logic signed [49:0] p1;
    logic signed [49:0] p2;
    for (int i = 0; i < 3; i++) begin
      qs = signed'(quo[i]);
      if (over_r[S_V1-1]) begin
        fl = frc_r[S_V1-1][i][WORD_BITS-1] ? -qs : qs;
      end else begin
        fl = frc_r[S_V1-1][i];
      end
      p1 = 50'(signed'({1'b0, cfg.time_step})) * 50'(fl);
      p2 = 50'(signed'({1'b0, cfg.xsph_factor})) * 50'(xs_r[S_V1-1][i]);
      t1_nxt[i] = 34'(p1 >>> FRAC_BITS);
      t2_nxt[i] = 34'(p2 >>> FRAC_BITS);
    end
  end

  // New velocity.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vn_nxt[i] = sat_word(64'(vel_r[S_V2-1][i]) + 64'(t1_r[i]) + 64'(t2_r[i]));
    end
  end

  // Position step dt*v and the mean velocity.
  always_comb begin
    logic signed [49:0] p3;
    logic signed [32:0] vs;
    for (int i = 0; i < 3; i++) begin
      p3          = 50'(signed'({1'b0, cfg.time_step})) * 50'(vn_r[S_V2][i]);
      step_nxt[i] = sat_word(64'(p3 >>> FRAC_BITS));
      vs          = 33'(vel_r[S_V3-1][i]) + 33'(vn_r[S_V2][i]);
      mean_nxt[i] = 32'(vs >>> 1);
    end
  end

  // Scale the step by the inverse simulation scale.
  always_comb begin
    logic signed [63:0] p4;
    for (int i = 0; i < 3; i++) begin
      p4        = 64'(step_r[i]) * 64'(signed'({1'b0, cfg.inv_sim_scale}));
      ps_nxt[i] = 48'(p4 >>> FRAC_BITS);
    end
  end

  // New position and the result request.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      np[i] = sat_word(64'(pos_r[S_V4][i]) + 64'(ps_r[i]));
    end
    item_nxt.new_pos_x  = np[0];
    item_nxt.new_pos_y  = np[1];
    item_nxt.new_pos_z  = np[2];
    item_nxt.new_vel_x  = vn_r[S_V4][0];
    item_nxt.new_vel_y  = vn_r[S_V4][1];
    item_nxt.new_vel_z  = vn_r[S_V4][2];
    item_nxt.mean_vel_x = mean_r[S_V4][0];
    item_nxt.mean_vel_y = mean_r[S_V4][1];
    item_nxt.mean_vel_z = mean_r[S_V4][2];
  end

  // Pipeline data registers; all stages move together.
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r[S_IN] <= pos_in;
      vel_r[S_IN] <= vel_in;
      xs_r[S_IN]  <= xs_in;
      frc_r[S_IN] <= frc_in;
      for (int k = 1; k <= S_V4; k++) begin
        pos_r[k] <= pos_r[k-1];
      end
      for (int k = 1; k < S_V3; k++) begin
        vel_r[k] <= vel_r[k-1];
      end
      for (int k = 1; k < S_V1; k++) begin
        xs_r[k]  <= xs_r[k-1];
        frc_r[k] <= frc_r[k-1];
      end
      sq_r        <= sq_nxt;
      lim2_r      <= lim2_nxt;
      num_r[S_SQ] <= num_nxt;
      for (int k = S_SQ + 1; k < S_DIV0; k++) begin
        num_r[k] <= num_r[k-1];
      end
      sum_r          <= sum_nxt;
      over_r[S_SUM]  <= over_nxt;
      for (int k = S_SUM + 1; k < S_V1; k++) begin
        over_r[k] <= over_r[k-1];
      end
      t1_r         <= t1_nxt;
      t2_r         <= t2_nxt;
      vn_r[S_V2]   <= vn_nxt;
      vn_r[S_V3]   <= vn_r[S_V2];
      vn_r[S_V4]   <= vn_r[S_V3];
      step_r       <= step_nxt;
      mean_r[S_V3] <= mean_nxt;
      mean_r[S_V4] <= mean_r[S_V3];
      ps_r         <= ps_nxt;
    end
  end

  // Two-entry output buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf_r[wr_ptr_r] <= item_nxt;
    end
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.data  = obuf_r[rd_ptr_r];

endmodule

// ===== rtl/plu_checker.sv =====
// ----------------------------------------------------------------------------
// plu_checker
// Port-level checks of the particle leapfrog update block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plu_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);

  // A result request that is not taken stays offered.
  `PLU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result request dropped")

  // With no result waiting the buffer is empty, so requests are taken.
  `PLU_ASSERT_SAME(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")

  // A full buffer that drains one entry frees the input on the next cycle.
  `PLU_ASSERT_NEXT(a_ready_drain, !in_ready && out_ready, in_ready, "input stall not released")

  // The register port never inserts wait states.
  `PLU_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind particle_leapfrog_update plu_checker u_plu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pready    (pready)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the particle leapfrog update block. Requests go in
// over the valid/ready input channel. A predictor in the result scoreboard
// works out the expected update for each accepted request. Each result is
// compared field by field, in order. Registers are written over APB between
// phases while the block is idle. The phases cover extreme settings and
// several idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import plu_pkg::*;

  class leapfrog_scoreboard;
    logic [16:0]        time_step;
    logic signed [24:0] gravity_z;
    logic [30:0]        speed_limit;
    logic [16:0]        xsph_factor;
    logic [30:0]        inv_sim_scale;
    out_item_t          expected_updates[$];
    int                 errors;

    function new();
      time_step     = 17'd66;
      gravity_z     = -25'sd642253;
      speed_limit   = 31'd39321600;
      xsph_factor   = 17'd6554;
      inv_sim_scale = 31'd65536;
      errors        = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_TIME_STEP:     time_step     = value[16:0];
        REG_GRAVITY_Z:     gravity_z     = value[24:0];
        REG_SPEED_LIMIT:   speed_limit   = value[30:0];
        REG_XSPH_FACTOR:   xsph_factor   = value[16:0];
        REG_INV_SIM_SCALE: inv_sim_scale = value[30:0];
        default: ;
      endcase
    endfunction

    // Clamp to the signed 32-bit range.
    function logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Fixed-point product, rounded toward minus infinity.
    function logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] prod;
      prod = a * b;
      return prod >>> FRAC_BITS;
    endfunction

    function logic [63:0] int_root(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] one;
      res = 64'd0;
      one = 64'd1 << 62;
      while (one > n) one = one >> 2;
      while (one != 0) begin
        if (n >= res + one) begin
          n   = n - (res + one);
          res = (res >> 1) + one;
        end else begin
          res = res >> 1;
        end
        one = one >> 2;
      end
      return res;
    endfunction

    // Work out the expected update of one particle.
    function out_item_t leapfrog(in_item_t it);
      logic signed [63:0] p[3], v[3], f[3], xs[3], vn[3];
      logic signed [63:0] stp, mean;
      logic [63:0]        mag2, lim2, mag, a, q, sl;
      logic               neg;
      out_item_t          r;
      p[0] = it.pos_x;   p[1] = it.pos_y;   p[2] = it.pos_z;
      v[0] = it.vel_x;   v[1] = it.vel_y;   v[2] = it.vel_z;
      f[0] = it.force_x; f[1] = it.force_y; f[2] = it.force_z;
      xs[0] = it.xsph_x; xs[1] = it.xsph_y; xs[2] = it.xsph_z;
      f[2] = clamp32(f[2] + 64'(gravity_z));

      // Limit the force magnitude, comparing squares exactly.
      sl   = 64'(speed_limit);
      mag2 = 64'd0;
      for (int i = 0; i < 3; i++) mag2 = mag2 + 64'(f[i] * f[i]);
      lim2 = sl * sl;
      if (mag2 > lim2) begin
        mag = int_root(mag2);
        for (int i = 0; i < 3; i++) begin
          neg  = f[i] < 0;
          a    = neg ? 64'(-f[i]) : 64'(f[i]);
          q    = (a * sl) / mag;
          f[i] = neg ? -$signed(q) : $signed(q);
        end
      end

      for (int i = 0; i < 3; i++) begin
        vn[i] = clamp32(v[i] + fx_mul(64'(time_step), f[i])
                        + fx_mul(64'(xsph_factor), xs[i]));
        stp   = clamp32(fx_mul(64'(time_step), vn[i]));
        p[i]  = clamp32(p[i] + fx_mul(stp, 64'(inv_sim_scale)));
        mean  = (v[i] + vn[i]) >>> 1;
        v[i]  = mean;
      end
      r.new_pos_x  = p[0][31:0];  r.new_pos_y  = p[1][31:0];  r.new_pos_z  = p[2][31:0];
      r.new_vel_x  = vn[0][31:0]; r.new_vel_y  = vn[1][31:0]; r.new_vel_z  = vn[2][31:0];
      r.mean_vel_x = v[0][31:0];  r.mean_vel_y = v[1][31:0];  r.mean_vel_z = v[2][31:0];
      return r;
    endfunction

    function void note_request(in_item_t it);
      expected_updates.push_back(leapfrog(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      word_t     ew[9], gw[9];
      string     names[9];
      if (expected_updates.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp_r = expected_updates.pop_front();
      names = '{"new_pos_x", "new_pos_y", "new_pos_z", "new_vel_x", "new_vel_y",
                "new_vel_z", "mean_vel_x", "mean_vel_y", "mean_vel_z"};
      ew = '{exp_r.new_pos_x, exp_r.new_pos_y, exp_r.new_pos_z, exp_r.new_vel_x,
             exp_r.new_vel_y, exp_r.new_vel_z, exp_r.mean_vel_x, exp_r.mean_vel_y,
             exp_r.mean_vel_z};
      gw = '{got.new_pos_x, got.new_pos_y, got.new_pos_z, got.new_vel_x,
             got.new_vel_y, got.new_vel_z, got.mean_vel_x, got.mean_vel_y,
             got.mean_vel_z};
      for (int i = 0; i < 9; i++) begin
        if (ew[i] !== gw[i]) begin
          $error("%s expected %0d actual %0d", names[i], ew[i], gw[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_updates.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic        pready;
  int          cycles;
  bit          tx_idle;
  bit          rx_stall;
  int          idle_pct;
  int          hold_seq;
  int          hold_seen;
  int          hold_left;

  plu_in_if  in_ch();
  plu_out_if out_ch();

  leapfrog_scoreboard sb = new();

  particle_leapfrog_update dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock and cycle limit.
  initial begin
    clk    = 1'b0;
    cycles = 0;
    forever begin
      #5 clk = 1'b1;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
      #5 clk = 1'b0;
    end
  end

  // Result side: random stalls plus an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rx_stall ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;
    end
  end

  // Watch both channels; results are checked before the same-cycle request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_config(logic [16:0] ts, logic signed [24:0] gz, logic [30:0] sl,
                            logic [16:0] xf, logic [30:0] inv);
    reg_write(REG_TIME_STEP, 32'(ts));
    reg_write(REG_GRAVITY_Z, 32'(gz[24:0]));
    reg_write(REG_SPEED_LIMIT, 32'(sl));
    reg_write(REG_XSPH_FACTOR, 32'(xf));
    reg_write(REG_INV_SIM_SCALE, 32'(inv));
  endtask

  // Offer one request and hold it until accepted, then maybe go idle.
  task automatic send_request(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (tx_idle && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom);
      1: return word_t'($signed(33'($urandom_range(0, 1 << 21))) - 33'sd1048576);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return word_t'($signed(33'($urandom_range(0, 1 << 27))) - 33'sd67108864);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.pos_x   = rand_word(); it.pos_y   = rand_word(); it.pos_z   = rand_word();
    it.vel_x   = rand_word(); it.vel_y   = rand_word(); it.vel_z   = rand_word();
    it.force_x = rand_word(); it.force_y = rand_word(); it.force_z = rand_word();
    it.xsph_x  = rand_word(); it.xsph_y  = rand_word(); it.xsph_z  = rand_word();
    return it;
  endfunction

  function automatic in_item_t fill_item(word_t p, word_t v, word_t fx, word_t fz, word_t xs);
    in_item_t it;
    it = '{p, p, p, v, v, v, fx, fx, fz, xs, xs, xs};
    return it;
  endfunction

  initial begin
    in_item_t it;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    tx_idle     = 1'b0;
    rx_stall    = 1'b0;
    idle_pct    = 77;
    hold_seq    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset settings.
    send_request('0);
    send_request(fill_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                           32'sh7FFFFFFF));
    send_request(fill_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh80000000));
    send_request(fill_item(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
    // Force exactly at the limit once gravity is added: not rescaled.
    it = '0;
    it.force_x = 32'sd39321600;
    it.force_z = 32'sd642253;
    send_request(it);
    // Just above the limit: rescaled.
    it.force_x = 32'sd39321601;
    send_request(it);
    // Gravity pushes force z below the word range.
    it = '0;
    it.force_z = 32'sh80000000;
    send_request(it);
    // Large velocity plus force saturates the new velocity.
    send_request(fill_item(32'sd65536, 32'sh7FFF0000, 32'sd39000000, 32'sd0, 32'sh7FFFFFFF));
    send_request(fill_item(-32'sd65536, 32'sh80010000, -32'sd39000000, -32'sd39000000,
                           32'sh80000000));
    // Odd sums check the rounding of the mean toward minus infinity.
    send_request(fill_item(32'sd3, -32'sd3, 32'sd1, 32'sd5, -32'sd7));
    send_request(fill_item(32'sd12345, 32'sd1, -32'sd1, 32'sd642254, 32'sd1));
    for (int i = 0; i < 9; i++) send_request(rand_item());
    wait_idle();

    // Phases with different settings and idle patterns.
    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_config(17'd65536, 25'sd8388608, 31'h7FFFFFFF, 17'd65536, 31'h7FFFFFFF);
        2: set_config(17'd0, -25'sd8388608, 31'd0, 17'd0, 31'd0);
        3: set_config(17'($urandom_range(0, 65536)), 25'($signed($urandom_range(0, 1 << 24))
                      - 32'sd8388608), 31'($urandom), 17'($urandom_range(0, 65536)),
                      31'($urandom_range(0, 1 << 20)));
        4: set_config(17'd66, -25'sd642253, 31'd39321600, 17'd6554, 31'd65536);
        default: set_config(17'($urandom_range(0, 4096)), -25'sd642253,
                            31'($urandom_range(0, 1 << 28)), 17'($urandom_range(0, 65536)),
                            31'($urandom_range(1 << 14, 1 << 18)));
      endcase
      tx_idle  = (ph == 1) || (ph == 3) || (ph == 5);
      rx_stall = (ph == 2) || (ph == 3);
      // Both sides idle only lightly when they idle together.
      idle_pct = (ph == 3) ? 18 : 77;
      if (ph == 4) begin
        hold_seq = hold_seq + 1;
      end
      for (int n = 0; n < 76; n++) send_request(rand_item());
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
